/* hdl/rol_pkg.sv */
// ----------------------------------------------------------------------------
// Recursive owner lock package
// Types, codes and constants shared by the lock core and the top level.
// ----------------------------------------------------------------------------
package rol_pkg;

  localparam int unsigned REQ_W   = 4;
  localparam int unsigned FLAGS_W = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned DEPTH_W = 8;

  localparam logic [CNT_W-1:0] CNT_SAT           = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] RETRY_LIMIT_RESET = 32'd200000000;

  typedef enum logic {
    ACT_ACQUIRE = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_NESTED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_FORCED    = 3'd3,
    ST_NEST_REL  = 3'd4,
    ST_FINAL_REL = 3'd5,
    ST_BAD_REL   = 3'd6,
    ST_DEPTH_OVF = 3'd7
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [FLAGS_W-1:0]   restored_state;
    logic                 held;
    logic [REQ_W-1:0]     holder;
    logic [DEPTH_W-1:0]   nest_depth;
    logic [CNT_W-1:0]     bad_release_count;
    logic [CNT_W-1:0]     forced_take_count;
    logic [REQ_W-1:0]     forced_from;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] cnt;
  } retry_wr_t;

endpackage

/* hdl/recursive_owner_lock.sv */
// An accepted beat waits in the input register until the result register takes it.
// Throughput: one beat per cycle unless out_stall holds the output. The retry count
// of a requester is read at acceptance and written back at decision, with a bypass.
// Reset (rst_n, synchronous, active low) frees the lock, clears every counter
// and sets the retry limit to 200000000; retry counts clear at once via valid bits.
// ----------------------------------------------------------------------------
// Recursive owner lock
// Hardware recursive mutex keyed by requester id, with a retry timeout that
// lets a starved requester take the lock by force. Input register, retry
// count RAM, decision core and result register.
// ----------------------------------------------------------------------------
module recursive_owner_lock
  import rol_pkg::*;
#(
  parameter int unsigned NUM_REQUESTERS = 16,
  parameter int unsigned MAX_NEST       = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [REQ_W-1:0]   in_requester,
  input  logic [FLAGS_W-1:0] in_irq_state,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [FLAGS_W-1:0] out_restored_state,
  output logic               out_held,
  output logic [REQ_W-1:0]   out_holder,
  output logic [DEPTH_W-1:0] out_nest_depth,
  output logic [CNT_W-1:0]   out_bad_release_count,
  output logic [CNT_W-1:0]   out_forced_take_count,
  output logic [REQ_W-1:0]   out_forced_from,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data
);

  localparam int unsigned SLOT_W  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int unsigned NUM_IDS = 2 ** REQ_W;

  logic [SLOT_W-1:0] slot_tab [NUM_IDS];

  for (genvar g = 0; g < NUM_IDS; g++) begin : g_slot
    assign slot_tab[g] = SLOT_W'(g % NUM_REQUESTERS);
  end

  logic               s1_valid_r;
  action_t            s1_action_r;
  logic [REQ_W-1:0]   s1_requester_r;
  logic [FLAGS_W-1:0] s1_irq_r;
  logic [SLOT_W-1:0]  s1_slot_r;

  logic               out_valid_r;
  result_t            out_res_r;

  logic               out_advance;
  logic               s1_fire;
  logic               in_accept;
  logic [SLOT_W-1:0]  in_slot;

  logic [NUM_REQUESTERS-1:0] cnt_vld_r;
  logic                      rd_vld_r;
  logic                      byp_r;
  logic [CNT_W-1:0]          byp_cnt_r;
  logic [CNT_W-1:0]          ram_rdata;
  logic [CNT_W-1:0]          retry_cnt;

  result_t   core_res;
  retry_wr_t retry_wr;
  logic      ram_we;

  assign out_advance = !out_valid_r || !out_stall;
  assign s1_fire     = s1_valid_r && out_advance;
  assign in_stall    = s1_valid_r && !out_advance;
  assign in_accept   = in_valid && !in_stall;
  assign in_slot     = slot_tab[in_requester];
  assign ram_we      = s1_fire && retry_wr.we;

  rol_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_REQUESTERS)
  ) u_retry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot_r),
    .wdata (retry_wr.cnt),
    .re    (in_accept),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  assign retry_cnt = byp_r ? byp_cnt_r : (rd_vld_r ? ram_rdata : '0);

  rol_core #(
    .MAX_NEST (MAX_NEST)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .action      (s1_action_r),
    .requester   (s1_requester_r),
    .irq_state   (s1_irq_r),
    .retry_cnt   (retry_cnt),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (core_res),
    .retry_wr    (retry_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
      byp_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        cnt_vld_r[s1_slot_r] <= 1'b1;
      end
      if (in_accept) begin
        rd_vld_r <= cnt_vld_r[in_slot];
        byp_r    <= ram_we && (s1_slot_r == in_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r    <= action_t'(in_action);
      s1_requester_r <= in_requester;
      s1_irq_r       <= in_irq_state;
      s1_slot_r      <= in_slot;
      byp_cnt_r      <= retry_wr.cnt;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_res_r.status;
  assign out_restored_state    = out_res_r.restored_state;
  assign out_held              = out_res_r.held;
  assign out_holder            = out_res_r.holder;
  assign out_nest_depth        = out_res_r.nest_depth;
  assign out_bad_release_count = out_res_r.bad_release_count;
  assign out_forced_take_count = out_res_r.forced_take_count;
  assign out_forced_from       = out_res_r.forced_from;

  a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_held == (out_nest_depth != '0)))
    else $error("held flag disagrees with nesting depth");

  a_restore_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FINAL_REL) |-> (out_restored_state == '0))
    else $error("flags word returned outside a final release");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FINAL_REL) |-> !out_held && (out_holder == '0))
    else $error("final release left the lock held");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with no beat in flight");

endmodule

/* hdl/rol_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; the read data
// holds its value while no read is requested.
// ----------------------------------------------------------------------------
module rol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rol_core.sv */
// ----------------------------------------------------------------------------
// Recursive owner lock core
// Holds the lock state and counters and decides the outcome of one request
// combinationally, given the requester's current retry count.
// ----------------------------------------------------------------------------
module rol_core
  import rol_pkg::*;
#(
  parameter int unsigned MAX_NEST = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  action_t            action,
  input  logic [REQ_W-1:0]   requester,
  input  logic [FLAGS_W-1:0] irq_state,
  input  logic [CNT_W-1:0]   retry_cnt,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  output result_t            result,
  output retry_wr_t          retry_wr
);

  localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_W'((MAX_NEST > 255) ? 255 : MAX_NEST);

  logic [CNT_W-1:0]   limit_r;
  logic [REQ_W-1:0]   owner_r, owner_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [FLAGS_W-1:0] saved_r, saved_nxt;
  logic [CNT_W-1:0]   bad_r, bad_nxt;
  logic [CNT_W-1:0]   forced_r, forced_nxt;
  logic [REQ_W-1:0]   from_r, from_nxt;

  logic               held;
  logic               match;
  logic [CNT_W-1:0]   cnt_inc;
  status_t            status;
  logic [FLAGS_W-1:0] restored;

  assign held    = (depth_r != '0);
  assign match   = held && (owner_r == requester);
  assign cnt_inc = (retry_cnt == CNT_SAT) ? retry_cnt : retry_cnt + 1'b1;

  always_comb begin
    owner_nxt    = owner_r;
    depth_nxt    = depth_r;
    saved_nxt    = saved_r;
    bad_nxt      = bad_r;
    forced_nxt   = forced_r;
    from_nxt     = from_r;
    restored     = '0;
    retry_wr.we  = 1'b0;
    retry_wr.cnt = '0;
    status       = ST_BUSY;
    case (action)
      ACT_ACQUIRE: begin
        if (match) begin
          if (depth_r >= DEPTH_CAP) begin
            status = ST_DEPTH_OVF;
          end else begin
            depth_nxt = depth_r + 1'b1;
            status    = ST_NESTED;
          end
        end else if (!held) begin
          owner_nxt   = requester;
          depth_nxt   = DEPTH_W'(1);
          saved_nxt   = irq_state;
          retry_wr.we = 1'b1;
          status      = ST_GRANTED;
        end else begin
          retry_wr.we = 1'b1;
          if (cnt_inc > limit_r) begin
            forced_nxt = (forced_r == CNT_SAT) ? forced_r : forced_r + 1'b1;
            from_nxt   = owner_r;
            owner_nxt  = requester;
            depth_nxt  = DEPTH_W'(1);
            saved_nxt  = irq_state;
            status     = ST_FORCED;
          end else begin
            retry_wr.cnt = cnt_inc;
            status       = ST_BUSY;
          end
        end
      end
      ACT_RELEASE: begin
        if (!match) begin
          bad_nxt = (bad_r == CNT_SAT) ? bad_r : bad_r + 1'b1;
          status  = ST_BAD_REL;
        end else if (depth_r > DEPTH_W'(1)) begin
          depth_nxt = depth_r - 1'b1;
          status    = ST_NEST_REL;
        end else begin
          restored  = saved_r;
          depth_nxt = '0;
          owner_nxt = '0;
          saved_nxt = '0;
          status    = ST_FINAL_REL;
        end
      end
      default: begin
        status = ST_BUSY;
      end
    endcase
  end

  always_comb begin
    result.status            = status;
    result.restored_state    = restored;
    result.held              = (depth_nxt != '0);
    result.holder            = (depth_nxt != '0) ? owner_nxt : '0;
    result.nest_depth        = depth_nxt;
    result.bad_release_count = bad_nxt;
    result.forced_take_count = forced_nxt;
    result.forced_from       = from_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= RETRY_LIMIT_RESET;
      owner_r  <= '0;
      depth_r  <= '0;
      saved_r  <= '0;
      bad_r    <= '0;
      forced_r <= '0;
      from_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (fire) begin
        owner_r  <= owner_nxt;
        depth_r  <= depth_nxt;
        saved_r  <= saved_nxt;
        bad_r    <= bad_nxt;
        forced_r <= forced_nxt;
        from_r   <= from_nxt;
      end
    end
  end

  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_CAP)
    else $error("nesting depth beyond its cap");

  a_idle_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !held |-> (owner_r == '0) && (saved_r == '0))
    else $error("free lock keeps an owner or a saved flags word");

  a_forced_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> forced_r >= $past(forced_r))
    else $error("forced-take count went down");

endmodule

/* sim/tb_recursive_owner_lock.sv */
// ----------------------------------------------------------------------------
// Recursive owner lock testbench
// Drives acquire and release beats into the lock and checks every result beat
// against a cycle-free model of the lock kept inside the bench. The run
// starts with a short directed sequence. Random lock sessions with contenders
// and noise follow under several retry limits, including a nesting run to the
// depth limit. Both sides idle in random bursts, except in the last run.
// ----------------------------------------------------------------------------
module tb_recursive_owner_lock;
  import rol_pkg::*;

  localparam int unsigned NREQ        = 16;
  localparam int unsigned NEST_MAX    = 255;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    action_t            action;
    logic [REQ_W-1:0]   requester;
    logic [FLAGS_W-1:0] flags;
  } lock_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic [REQ_W-1:0]   in_requester = '0;
  logic [FLAGS_W-1:0] in_irq_state = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [FLAGS_W-1:0] out_restored_state;
  logic               out_held;
  logic [REQ_W-1:0]   out_holder;
  logic [DEPTH_W-1:0] out_nest_depth;
  logic [CNT_W-1:0]   out_bad_release_count;
  logic [CNT_W-1:0]   out_forced_take_count;
  logic [REQ_W-1:0]   out_forced_from;
  logic               cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;

  lock_req_t pending_reqs[$];
  result_t   expected_results[$];
  int        errors = 0;
  int        cycles = 0;
  int        src_gap = 0;
  int        sink_gap = 0;
  bit        idle_on = 1'b1;

  logic [REQ_W-1:0]   lk_owner = '0;
  logic [DEPTH_W-1:0] lk_depth = '0;
  logic [FLAGS_W-1:0] lk_saved = '0;
  logic [CNT_W-1:0]   lk_bad = '0;
  logic [CNT_W-1:0]   lk_forced = '0;
  logic [REQ_W-1:0]   lk_from = '0;
  logic [CNT_W-1:0]   lk_retry[NREQ];
  logic [CNT_W-1:0]   lk_limit = RETRY_LIMIT_RESET;

  recursive_owner_lock #(
    .NUM_REQUESTERS(NREQ),
    .MAX_NEST      (NEST_MAX)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_requester         (in_requester),
    .in_irq_state         (in_irq_state),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_restored_state   (out_restored_state),
    .out_held             (out_held),
    .out_holder           (out_holder),
    .out_nest_depth       (out_nest_depth),
    .out_bad_release_count(out_bad_release_count),
    .out_forced_take_count(out_forced_take_count),
    .out_forced_from      (out_forced_from),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_recursive_owner_lock: done, errors");
      $finish;
    end
  end

  function automatic void seize_lock(logic [REQ_W-1:0] who, int unsigned slot,
                                     logic [FLAGS_W-1:0] flags);
    lk_owner = who;
    lk_depth = DEPTH_W'(1);
    lk_saved = flags;
    lk_retry[slot] = '0;
  endfunction

  function automatic result_t predict_lock_result(action_t act, logic [REQ_W-1:0] who,
                                                  logic [FLAGS_W-1:0] flags);
    result_t     r;
    int unsigned slot;
    logic        held;
    slot = who % NREQ;
    held = (lk_depth != 0);
    r.restored_state = '0;
    if (act == ACT_ACQUIRE) begin
      if (held && lk_owner == who) begin
        if (lk_depth >= NEST_MAX) begin
          r.status = ST_DEPTH_OVF;
        end else begin
          lk_depth++;
          r.status = ST_NESTED;
        end
      end else if (!held) begin
        seize_lock(who, slot, flags);
        r.status = ST_GRANTED;
      end else begin
        if (lk_retry[slot] != CNT_SAT) lk_retry[slot]++;
        if (lk_retry[slot] > lk_limit) begin
          if (lk_forced != CNT_SAT) lk_forced++;
          lk_from = lk_owner;
          seize_lock(who, slot, flags);
          r.status = ST_FORCED;
        end else begin
          r.status = ST_BUSY;
        end
      end
    end else begin
      if (!held || lk_owner != who) begin
        if (lk_bad != CNT_SAT) lk_bad++;
        r.status = ST_BAD_REL;
      end else if (lk_depth > 1) begin
        lk_depth--;
        r.status = ST_NEST_REL;
      end else begin
        r.restored_state = lk_saved;
        lk_depth = '0;
        lk_owner = '0;
        lk_saved = '0;
        r.status = ST_FINAL_REL;
      end
    end
    r.held              = (lk_depth != 0);
    r.holder            = r.held ? lk_owner : '0;
    r.nest_depth        = lk_depth;
    r.bad_release_count = lk_bad;
    r.forced_take_count = lk_forced;
    r.forced_from       = lk_from;
    return r;
  endfunction

  function automatic string show_result(result_t r);
    return $sformatf("st=%0d rs=%h held=%0d holder=%0d depth=%0d bad=%0d forced=%0d from=%0d",
                     r.status, r.restored_state, r.held, r.holder, r.nest_depth,
                     r.bad_release_count, r.forced_take_count, r.forced_from);
  endfunction

  task automatic log_mismatch(string what, result_t want, result_t seen);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected %s, got %s", what, show_result(want),
               show_result(seen));
  endtask

  always @(posedge clk) begin : drive_proc
    lock_req_t nxt;
    logic      accepted;
    logic      drive;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && !in_stall;
      if (accepted)
        expected_results.push_back(
          predict_lock_result(action_t'(in_action), in_requester, in_irq_state));
      if (!in_valid || accepted) begin
        drive = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          drive = 1'b1;
          in_action    <= nxt.action;
          in_requester <= nxt.requester;
          in_irq_state <= nxt.flags;
          if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 18);
        end
        in_valid <= drive;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    result_t seen;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.status            = status_t'(out_status);
        seen.restored_state    = out_restored_state;
        seen.held              = out_held;
        seen.holder            = out_holder;
        seen.nest_depth        = out_nest_depth;
        seen.bad_release_count = out_bad_release_count;
        seen.forced_take_count = out_forced_take_count;
        seen.forced_from       = out_forced_from;
        if (expected_results.size() == 0) begin
          log_mismatch("unexpected beat", '0, seen);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) log_mismatch("field", want, seen);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [FLAGS_W-1:0] rand_flags();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(action_t act, logic [REQ_W-1:0] who, logic [FLAGS_W-1:0] flags);
    lock_req_t r;
    r.action    = act;
    r.requester = who;
    r.flags     = flags;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_retry_limit(logic [CNT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lk_limit = value;
  endtask

  task automatic push_contender(logic [REQ_W-1:0] owner);
    if ($urandom_range(0, 99) < 40)
      push_req(ACT_ACQUIRE, REQ_W'((owner + $urandom_range(1, NREQ - 1)) % NREQ),
               rand_flags());
  endtask

  task automatic build_traffic(int n_items);
    int               start;
    int               depth;
    int               drop;
    logic [REQ_W-1:0] owner;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        push_req(action_t'($urandom_range(0, 1)), REQ_W'($urandom_range(0, NREQ - 1)),
                 rand_flags());
      end else begin
        owner = REQ_W'($urandom_range(0, NREQ - 1));
        depth = $urandom_range(1, 4);
        drop  = ($urandom_range(0, 9) == 0) ? 1 : 0;
        for (int i = 0; i < depth; i++) begin
          push_req(ACT_ACQUIRE, owner, rand_flags());
          push_contender(owner);
        end
        for (int i = 0; i < depth - drop; i++) begin
          push_req(ACT_RELEASE, owner, rand_flags());
          push_contender(owner);
        end
      end
    end
  endtask

  task automatic deep_nest(logic [REQ_W-1:0] owner);
    for (int i = 0; i < NEST_MAX + 2; i++) push_req(ACT_ACQUIRE, owner, rand_flags());
    for (int i = 0; i < NEST_MAX + 1; i++) push_req(ACT_RELEASE, owner, rand_flags());
  endtask

  initial begin : stimulus
    for (int i = 0; i < NREQ; i++) lk_retry[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_req(ACT_ACQUIRE, 4'd0, '1);
    push_req(ACT_ACQUIRE, 4'd0, rand_flags());
    push_req(ACT_ACQUIRE, 4'd15, rand_flags());
    push_req(ACT_RELEASE, 4'd15, rand_flags());
    push_req(ACT_RELEASE, 4'd0, rand_flags());
    push_req(ACT_RELEASE, 4'd0, rand_flags());
    push_req(ACT_RELEASE, 4'd3, rand_flags());
    push_req(ACT_ACQUIRE, 4'd15, '0);
    push_req(ACT_ACQUIRE, 4'd15, rand_flags());
    push_req(ACT_RELEASE, 4'd15, rand_flags());
    push_req(ACT_RELEASE, 4'd15, rand_flags());

    // With a zero limit the very first refused attempt takes the lock.
    set_retry_limit('0);
    push_req(ACT_ACQUIRE, 4'd5, 64'hA5A5_A5A5_A5A5_A5A5);
    push_req(ACT_ACQUIRE, 4'd9, 64'h5A5A_5A5A_5A5A_5A5A);
    push_req(ACT_RELEASE, 4'd5, rand_flags());
    push_req(ACT_RELEASE, 4'd9, rand_flags());

    set_retry_limit(32'd1);
    push_req(ACT_ACQUIRE, 4'd2, rand_flags());
    push_req(ACT_ACQUIRE, 4'd7, rand_flags());
    push_req(ACT_ACQUIRE, 4'd7, rand_flags());
    push_req(ACT_ACQUIRE, 4'd7, rand_flags());
    push_req(ACT_RELEASE, 4'd7, rand_flags());
    push_req(ACT_RELEASE, 4'd7, rand_flags());
    build_traffic(170);

    set_retry_limit(32'd3);
    build_traffic(170);

    set_retry_limit(CNT_SAT);
    deep_nest(REQ_W'($urandom_range(0, NREQ - 1)));
    build_traffic(130);

    set_retry_limit('0);
    build_traffic(170);

    set_retry_limit(32'd7);
    build_traffic(170);

    set_retry_limit(RETRY_LIMIT_RESET);
    wait_idle();
    idle_on = 1'b0;
    build_traffic(160);

    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_recursive_owner_lock: done, clean");
    end else begin
      $display("tb_recursive_owner_lock: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rol_pkg.sv
hdl/rol_ram.sv
hdl/rol_core.sv
hdl/recursive_owner_lock.sv
sim/tb_recursive_owner_lock.sv
